// ===== design/kbm_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the tag byte update function of the keyed byte mac tag core
// no dependencies
package kbm_pkg;

    localparam int DATA_W    = 8;
    localparam int WORD_W    = 32;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_A_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_A_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B_LO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B_HI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_LO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_HI  = 3'd5;

    localparam logic [WORD_W-1:0] CFG_RESET [NUM_REGS] = '{
        32'h3B9A16AC, 32'hECC2FCE7, 32'h28175FD8,
        32'hCA8D7FF7, 32'h89C2BFA1, 32'hAD0077EB
    };

    // per tag byte constants, bytes 0..3 use key a, bytes 4..7 key b
    localparam logic [DATA_W-1:0] C_MULT [8] = '{
        8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23
    };

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } t_phase;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef struct packed {
        logic [7:0][DATA_W-1:0] key_a;
        logic [7:0][DATA_W-1:0] key_b;
        logic [7:0][DATA_W-1:0] seed;
    } t_cfg;

    // one tag byte: kd*d + kx*tx + kc*c + (ts ^ d), mod 256
    function automatic logic [DATA_W-1:0] tag_term(
        input logic [DATA_W-1:0] k_d,
        input logic [DATA_W-1:0] d,
        input logic [DATA_W-1:0] k_x,
        input logic [DATA_W-1:0] t_x,
        input logic [DATA_W-1:0] k_c,
        input logic [DATA_W-1:0] c,
        input logic [DATA_W-1:0] t_s
    );
        logic [2*DATA_W-1:0] p_d;
        logic [2*DATA_W-1:0] p_x;
        logic [2*DATA_W-1:0] p_c;
        logic [2*DATA_W-1:0] s;
        p_d = k_d * d;
        p_x = k_x * t_x;
        p_c = k_c * c;
        s   = p_d + p_x + p_c + {{DATA_W{1'b0}}, t_s ^ d};
        return s[DATA_W-1:0];
    endfunction

endpackage

// ===== design/kbm_in_if.sv =====
`timescale 1ns / 1ps
// message byte channel: valid, ready and one byte with its last flag
// depends on kbm_pkg
interface kbm_in_if import kbm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ===== design/kbm_out_if.sv =====
`timescale 1ns / 1ps
// tag result channel: valid, ready and the eight tag bytes as two words
// depends on kbm_pkg
interface kbm_out_if import kbm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] tag_low;
    logic [WORD_W-1:0] tag_high;

    modport source (output valid, output tag_low, output tag_high, input ready);
    modport sink   (input valid, input tag_low, input tag_high, output ready);
endinterface

// ===== design/keyed_byte_mac_tag_core.sv =====
`timescale 1ns / 1ps
// top level of the keyed byte mac tag core: configuration registers, front queue, back end
// depends on kbm_pkg, kbm_in_if, kbm_out_if, kbm_front and kbm_back
//
//  channel   dir  handshake          payload
//  i_in      in   valid / ready      data_byte[7:0], last
//  o_out     out  valid / ready      tag_low[31:0], tag_high[31:0]
//  cfg       in   i_cfg_wr_en        i_cfg_idx[2:0], i_cfg_data[31:0]
//
// each byte passes a first and a second phase in the back end: tag bytes 0,1 (and 4,5) first,
//   then 2,3 (and 6,7), since bytes 2,3 multiply the freshly updated bytes 1,0
// a 2-beat queue in front accepts beats while the back end works or a result waits
// the tag register on o_out holds a result until taken; only a last byte stalls on it
// synchronous active-low reset restores the registers and loads the tag from the reset seed
// writes to register indexes beyond the seed high word are dropped
module keyed_byte_mac_tag_core import kbm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    kbm_in_if.sink               i_in,
    kbm_out_if.source            o_out,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    // configuration register file
    logic [WORD_W-1:0] r_cfg [NUM_REGS];
    t_cfg              cfg;
    t_qhead            head;
    logic              pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < NUM_REGS; n++) begin
                r_cfg[n] <= CFG_RESET[n];
            end
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_KEY_A_LO: r_cfg[REG_KEY_A_LO] <= i_cfg_data;
                REG_KEY_A_HI: r_cfg[REG_KEY_A_HI] <= i_cfg_data;
                REG_KEY_B_LO: r_cfg[REG_KEY_B_LO] <= i_cfg_data;
                REG_KEY_B_HI: r_cfg[REG_KEY_B_HI] <= i_cfg_data;
                REG_SEED_LO:  r_cfg[REG_SEED_LO]  <= i_cfg_data;
                REG_SEED_HI:  r_cfg[REG_SEED_HI]  <= i_cfg_data;
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // byte n of each key or seed sits at bits 8n+7:8n of the low/high word pair
    assign cfg.key_a = {r_cfg[REG_KEY_A_HI], r_cfg[REG_KEY_A_LO]};
    assign cfg.key_b = {r_cfg[REG_KEY_B_HI], r_cfg[REG_KEY_B_LO]};
    assign cfg.seed  = {r_cfg[REG_SEED_HI], r_cfg[REG_SEED_LO]};

    // front: beat acceptance and queue
    kbm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (pop),
        .o_head  (head)
    );

    // back: tag update engine and result register
    kbm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .i_cfg   (cfg),
        .o_out   (o_out)
    );

endmodule

// ===== design/kbm_front.sv =====
`timescale 1ns / 1ps
// front end: accepts message beats into a short flip-flop queue for the back end
// depends on kbm_pkg and kbm_in_if
module kbm_front import kbm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kbm_in_if.sink        i_in,
    input  logic          i_pop,
    output t_qhead        o_head
);

    t_item               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  n_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_PTR_W-1:0]  n_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic [Q_CNT_W-1:0]  n_count;
    logic                push;
    logic                pop;

    assign i_in.ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{data_byte: i_in.data_byte, last: i_in.last};
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== design/kbm_back.sv =====
`timescale 1ns / 1ps
// back end: two-phase tag update per byte, tag result register and seed reload
// depends on kbm_pkg and kbm_out_if
module kbm_back import kbm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_qhead        i_head,
    output logic          o_pop,
    input  t_cfg          i_cfg,
    kbm_out_if.source     o_out
);

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [7:0][DATA_W-1:0] r_tag;
    logic [7:0][DATA_W-1:0] n_tag;
    logic [7:0][DATA_W-1:0] upd_tag;
    logic [7:0][DATA_W-1:0] key;
    logic [DATA_W-1:0]      r_d;
    logic                   r_last;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [WORD_W-1:0]      r_out_low;
    logic [WORD_W-1:0]      r_out_high;
    logic                   advance;
    logic                   emit;

    assign o_out.valid    = r_out_valid;
    assign o_out.tag_low  = r_out_low;
    assign o_out.tag_high = r_out_high;

    // second phase stalls only when a last byte meets a full result register
    assign advance = !r_last || !r_out_valid || o_out.ready;
    assign emit    = (r_phase == PH_SECOND) && r_last && advance;
    assign o_pop   = (r_phase == PH_FIRST) && i_head.valid;

    // bytes 0,1 of each half in the first phase, 2,3 in the second
    always_comb begin
        upd_tag = r_tag;
        key     = '0;
        for (int h = 0; h < 2; h++) begin
            key = (h == 0) ? i_cfg.key_a : i_cfg.key_b;
            upd_tag[4*h+0] = tag_term(key[0], i_head.item.data_byte, key[1], r_tag[4*h+3],
                                      key[7], C_MULT[4*h+0], r_tag[4*h+0]);
            upd_tag[4*h+1] = tag_term(key[1], i_head.item.data_byte, key[2], r_tag[4*h+2],
                                      key[6], C_MULT[4*h+1], r_tag[4*h+1]);
            upd_tag[4*h+2] = tag_term(key[2], r_d, key[3], r_tag[4*h+1],
                                      key[5], C_MULT[4*h+2], r_tag[4*h+2]);
            upd_tag[4*h+3] = tag_term(key[3], r_d, key[0], r_tag[4*h+0],
                                      key[4], C_MULT[4*h+3], r_tag[4*h+3]);
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_tag       = r_tag;
        n_out_valid = r_out_valid && !o_out.ready;
        unique case (r_phase)
            PH_FIRST: begin
                if (i_head.valid) begin
                    n_tag[0] = upd_tag[0];
                    n_tag[1] = upd_tag[1];
                    n_tag[4] = upd_tag[4];
                    n_tag[5] = upd_tag[5];
                    n_phase  = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (advance) begin
                    n_phase = PH_FIRST;
                    if (r_last) begin
                        n_tag       = i_cfg.seed;
                        n_out_valid = 1'b1;
                    end else begin
                        n_tag[2] = upd_tag[2];
                        n_tag[3] = upd_tag[3];
                        n_tag[6] = upd_tag[6];
                        n_tag[7] = upd_tag[7];
                    end
                end
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
            r_tag       <= {CFG_RESET[REG_SEED_HI], CFG_RESET[REG_SEED_LO]};
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_tag       <= n_tag;
            if (o_pop) begin
                r_last <= i_head.item.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_d <= i_head.item.data_byte;
        end
        if (emit) begin
            r_out_low  <= {upd_tag[3], upd_tag[2], r_tag[1], r_tag[0]};
            r_out_high <= {upd_tag[7], upd_tag[6], r_tag[5], r_tag[4]};
        end
    end

    a_pop_then_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIRST && i_head.valid) |=> (r_phase == PH_SECOND))
        else $error("first phase did not hand over to second phase");

    a_reload_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_tag == $past(i_cfg.seed)))
        else $error("tag not reloaded from seed after last byte");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_phase == PH_SECOND && r_last))
        else $error("result raised without a finished last byte");

endmodule
